FILE: src/vu_pkg.sv
package vu_pkg;

    localparam int LVL_W = 7;
    localparam int SEG_W = 5;
    localparam int LIT_W = 6;
    localparam int COL_W = 16;
    localparam int LIM_W = 9;
    localparam int T_W   = 9;

    localparam logic [LVL_W-1:0] LEVEL_MAX   = 7'd100;
    localparam logic [6:0]       MUTE_Q8     = 7'd115;
    localparam logic [12:0]      RECIP_100   = 13'd5243;
    localparam int               RECIP_SHIFT = 19;
    localparam logic [T_W-1:0]   T_ONE       = 9'd256;

    typedef enum logic [2:0] {
        CFG_GREEN  = 3'd0,
        CFG_ORANGE = 3'd1,
        CFG_RED    = 3'd2,
        CFG_TRACK  = 3'd3,
        CFG_RISE   = 3'd4,
        CFG_FALL   = 3'd5,
        CFG_GLIM   = 3'd6,
        CFG_OLIM   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SRC_TRACK = 2'd0,
        SRC_LOW   = 2'd1,
        SRC_HIGH  = 2'd2,
        SRC_RED   = 2'd3
    } t_col_src;

    typedef struct packed {
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] orange;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] track;
        logic [LVL_W-1:0] rise;
        logic [LVL_W-1:0] fall;
        logic [LIM_W-1:0] glim;
        logic [LIM_W-1:0] olim;
    } t_cfg;

    typedef struct packed {
        logic                  muted;
        logic [1:0][LVL_W-1:0] level;
        logic [1:0][LIT_W-1:0] lit;
    } t_job;

    typedef struct packed {
        logic             side;
        logic [SEG_W-1:0] seg;
        logic             lit;
        logic             last;
        logic [LVL_W-1:0] level;
        logic             muted;
    } t_meta;

endpackage

FILE: src/vu_front.sv
module vu_front #(
    parameter int CHANNELS = 4,
    parameter int SEGMENTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_channel,
    input  logic [7:0]    i_left_level,
    input  logic [7:0]    i_right_level,
    input  logic          i_muted,
    input  vu_pkg::t_cfg  i_cfg,
    output logic          o_job_valid,
    output vu_pkg::t_job  o_job,
    input  logic          i_job_full
);
    import vu_pkg::*;

    localparam int NCH = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [2:0] NCH_V = 3'(NCH);

    logic             r_valid;
    logic [1:0]       r_ch;
    logic [1:0][7:0]  r_lvl_in;
    logic             r_muted;
    logic [LVL_W-1:0] r_lvl [NCH][2];

    logic             in_range;
    logic             drain;
    logic             accept;
    logic [IW-1:0]    idx;
    logic [1:0][LVL_W-1:0] n_lvl;

    function automatic logic [LVL_W-1:0] step_level(
        input logic [LVL_W-1:0] lv,
        input logic [7:0]       lvl_in,
        input logic [LVL_W-1:0] rise,
        input logic [LVL_W-1:0] fall
    );
        logic [LVL_W-1:0] target;
        logic [LVL_W:0]   sum;
        logic [LVL_W:0]   lim;
        logic [LVL_W-1:0] res;
        target = (lvl_in > 8'(LEVEL_MAX)) ? LEVEL_MAX : lvl_in[LVL_W-1:0];
        if (target > lv) begin
            sum = {1'b0, lv} + {1'b0, rise};
            res = (sum > {1'b0, target}) ? target : sum[LVL_W-1:0];
        end else begin
            lim = {1'b0, target} + {1'b0, fall};
            res = ({1'b0, lv} >= lim) ? (lv - fall) : target;
        end
        return res;
    endfunction

    function automatic logic [LIT_W-1:0] lit_count(input logic [LVL_W-1:0] lv);
        logic [11:0] x;
        logic [24:0] p;
        x = 12'(lv) * 12'(SEGMENTS);
        p = 25'(x) * 25'(RECIP_100);
        return p[RECIP_SHIFT +: LIT_W];
    endfunction

    assign idx      = r_ch[IW-1:0];
    assign in_range = {1'b0, r_ch} < NCH_V;
    assign drain    = r_valid && (!i_job_full || !in_range);
    assign o_full   = r_valid && !drain;
    assign accept   = i_push && !o_full;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            n_lvl[s] = step_level(r_lvl[idx][s], r_lvl_in[s], i_cfg.rise, i_cfg.fall);
        end
        o_job_valid = drain && in_range;
        o_job.muted = r_muted;
        for (int s = 0; s < 2; s++) begin
            o_job.level[s] = n_lvl[s];
            o_job.lit[s]   = lit_count(n_lvl[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch        <= i_channel;
            r_lvl_in[0] <= i_left_level;
            r_lvl_in[1] <= i_right_level;
            r_muted     <= i_muted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_lvl[c][0] <= '0;
                r_lvl[c][1] <= '0;
            end
        end else if (o_job_valid) begin
            r_lvl[idx][0] <= n_lvl[0];
            r_lvl[idx][1] <= n_lvl[1];
        end
    end

endmodule

FILE: src/vu_fifo.sv
module vu_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  vu_pkg::t_job i_data,
    output logic         o_full,
    input  logic         i_pop,
    output vu_pkg::t_job o_data,
    output logic         o_empty
);
    import vu_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            unique case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/vu_back.sv
module vu_back #(
    parameter int SEGMENTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vu_pkg::t_cfg  i_cfg,
    input  logic          i_job_empty,
    input  vu_pkg::t_job  i_job,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_side,
    output logic [4:0]    o_segment,
    output logic          o_lit,
    output logic [15:0]   o_segment_color,
    output logic [6:0]    o_level,
    output logic          o_last
);
    import vu_pkg::*;

    localparam int RW = $clog2(SEGMENTS) + 1;
    localparam logic [T_W-1:0]   F_Q     = T_W'(256 / SEGMENTS);
    localparam logic [RW-1:0]    F_R     = RW'(256 % SEGMENTS);
    localparam logic [RW-1:0]    F_N     = RW'(SEGMENTS);
    localparam logic [SEG_W-1:0] SEG_END = SEG_W'(SEGMENTS - 1);
    localparam int DIV_ST = 3;

    typedef struct packed {
        logic [16:0]    rem;
        logic [T_W-1:0] q;
    } t_div;

    logic             r_side;
    logic [SEG_W-1:0] r_seg;
    logic [T_W-1:0]   r_fq;
    logic [RW-1:0]    r_fr;

    logic             r_dv   [DIV_ST+1];
    logic [16:0]      r_rem  [DIV_ST+1];
    logic [LIM_W-1:0] r_den  [DIV_ST+1];
    logic [T_W-1:0]   r_q    [DIV_ST+1];
    t_col_src         r_src  [DIV_ST+1];
    t_meta            r_meta [DIV_ST+1];

    logic             r_cv;
    logic [COL_W-1:0] r_col;
    t_meta            r_cmeta;

    logic             r_ov;
    logic [COL_W-1:0] r_ocol;
    t_meta            r_ometa;

    logic             adv;
    logic             issue;
    logic             seg_end;
    logic [RW-1:0]    fr_sum;
    logic [T_W-1:0]   n_fq;
    logic [RW-1:0]    n_fr;
    t_meta            meta0;
    t_col_src         src0;
    logic [LIM_W-1:0] num0;
    logic [LIM_W-1:0] den0;
    logic [T_W-1:0]   t_cl;
    logic [COL_W-1:0] n_col;

    function automatic t_div div3(
        input logic [16:0]      rem,
        input logic [LIM_W-1:0] den,
        input logic [T_W-1:0]   q,
        input int               top
    );
        t_div        res;
        logic [17:0] d;
        logic [17:0] rr;
        int          i;
        rr    = {1'b0, rem};
        res.q = q;
        for (int j = 0; j < 3; j++) begin
            i = top - j;
            d = {9'b0, den} << i;
            if (rr >= d) begin
                rr       = rr - d;
                res.q[i] = 1'b1;
            end
        end
        res.rem = rr[16:0];
        return res;
    endfunction

    function automatic logic [5:0] lerp_c(
        input logic [5:0]     a,
        input logic [5:0]     b,
        input logic [T_W-1:0] t
    );
        logic signed [6:0]  d;
        logic signed [9:0]  ts;
        logic signed [16:0] p;
        logic signed [16:0] pa;
        logic signed [16:0] sh;
        d  = $signed({1'b0, b}) - $signed({1'b0, a});
        ts = $signed({1'b0, t});
        p  = d * ts;
        pa = p + (p[16] ? 17'sd255 : 17'sd0);
        sh = pa >>> 8;
        return a + sh[5:0];
    endfunction

    function automatic logic [COL_W-1:0] lerp565(
        input logic [COL_W-1:0] a,
        input logic [COL_W-1:0] b,
        input logic [T_W-1:0]   t
    );
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] bl;
        r  = lerp_c({1'b0, a[15:11]}, {1'b0, b[15:11]}, t);
        g  = lerp_c(a[10:5], b[10:5], t);
        bl = lerp_c({1'b0, a[4:0]}, {1'b0, b[4:0]}, t);
        return {r[4:0], g, bl[4:0]};
    endfunction

    function automatic logic [5:0] dim_c(input logic [5:0] c);
        logic [12:0] p;
        p = 13'(c) * 13'(MUTE_Q8);
        return {1'b0, p[12:8]};
    endfunction

    function automatic logic [COL_W-1:0] dim565(input logic [COL_W-1:0] c);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] bl;
        r  = dim_c({1'b0, c[15:11]});
        g  = dim_c(c[10:5]);
        bl = dim_c({1'b0, c[4:0]});
        return {r[4:0], g, bl[4:0]};
    endfunction

    assign adv       = !r_ov || i_pop;
    assign issue     = adv && !i_job_empty;
    assign seg_end   = r_seg == SEG_END;
    assign o_job_pop = issue && seg_end && r_side;

    always_comb begin
        fr_sum = r_fr + F_R;
        if (fr_sum >= F_N) begin
            n_fr = fr_sum - F_N;
            n_fq = r_fq + F_Q + T_W'(1);
        end else begin
            n_fr = fr_sum;
            n_fq = r_fq + F_Q;
        end
    end

    always_comb begin
        meta0.side  = r_side;
        meta0.seg   = r_seg;
        meta0.lit   = {1'b0, r_seg} < i_job.lit[r_side];
        meta0.last  = r_side && seg_end;
        meta0.level = i_job.level[r_side];
        meta0.muted = i_job.muted;
        num0 = r_fq;
        den0 = i_cfg.glim;
        priority if (!meta0.lit) begin
            src0 = SRC_TRACK;
        end else if (r_fq <= i_cfg.glim) begin
            src0 = SRC_LOW;
        end else if (r_fq <= i_cfg.olim) begin
            src0 = SRC_HIGH;
            num0 = r_fq - i_cfg.glim;
            den0 = i_cfg.olim - i_cfg.glim;
        end else begin
            src0 = SRC_RED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 1'b0;
            r_seg  <= '0;
            r_fq   <= F_Q;
            r_fr   <= F_R;
        end else if (issue) begin
            if (seg_end) begin
                r_seg  <= '0;
                r_fq   <= F_Q;
                r_fr   <= F_R;
                r_side <= !r_side;
            end else begin
                r_seg <= r_seg + SEG_W'(1);
                r_fq  <= n_fq;
                r_fr  <= n_fr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_ST; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= !i_job_empty;
            for (int k = 1; k <= DIV_ST; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_cv <= r_dv[DIV_ST];
            r_ov <= r_cv;
        end
    end

    always_comb begin
        t_cl = (r_q[DIV_ST] > T_ONE) ? T_ONE : r_q[DIV_ST];
        unique case (r_src[DIV_ST])
            SRC_TRACK: n_col = i_cfg.track;
            SRC_LOW:   n_col = lerp565(i_cfg.green, i_cfg.orange, t_cl);
            SRC_HIGH:  n_col = lerp565(i_cfg.orange, i_cfg.red, t_cl);
            SRC_RED:   n_col = i_cfg.red;
            default:   n_col = i_cfg.red;
        endcase
    end

    always_ff @(posedge i_clk) begin
        t_div st;
        if (adv) begin
            r_meta[0] <= meta0;
            r_src[0]  <= src0;
            r_den[0]  <= den0;
            r_rem[0]  <= {num0, 8'b0};
            r_q[0]    <= '0;
            for (int k = 1; k <= DIV_ST; k++) begin
                st = div3(r_rem[k-1], r_den[k-1], r_q[k-1], 8 - 3 * (k - 1));
                r_rem[k]  <= st.rem;
                r_q[k]    <= st.q;
                r_den[k]  <= r_den[k-1];
                r_src[k]  <= r_src[k-1];
                r_meta[k] <= r_meta[k-1];
            end
            r_col   <= n_col;
            r_cmeta <= r_meta[DIV_ST];
            r_ocol  <= r_cmeta.muted ? dim565(r_col) : r_col;
            r_ometa <= r_cmeta;
        end
    end

    assign o_empty         = !r_ov;
    assign o_side          = r_ometa.side;
    assign o_segment       = r_ometa.seg;
    assign o_lit           = r_ometa.lit;
    assign o_segment_color = r_ocol;
    assign o_level         = r_ometa.level;
    assign o_last          = r_ometa.last;

endmodule

FILE: src/segmented_vu_meter_driver_top.sv
// Channel   Direction  Handshake          Beat
// input     in         push / full        channel, left_level, right_level, muted
// result    out        empty / pop        side, segment, lit, segment_color, level, last
// config    in         i_cfg_we           i_cfg_addr, i_cfg_data
//
// The sequencer issues 2*SEGMENTS segments per item, one per cycle unless pop stalls.
// An item is registered in the front end, held there while the job queue is full, and
// then written into the queue. Each segment passes the divider stages, the colour
// register and the output register. Reset is synchronous and active low; it clears the
// display levels, valid flags and queue pointers. A stall on pop freezes the colour
// pipeline; the two-entry job queue lets the input side take beats until it fills.
module segmented_vu_meter_driver_top #(
    parameter int CHANNELS = 4,
    parameter int SEGMENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_left_level,
    input  logic [7:0]  i_right_level,
    input  logic        i_muted,
    output logic        empty,
    input  logic        pop,
    output logic        o_side,
    output logic [4:0]  o_segment,
    output logic        o_lit,
    output logic [15:0] o_segment_color,
    output logic [6:0]  o_level,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import vu_pkg::*;

    t_cfg r_cfg;
    t_job fe_job;
    t_job q_job;
    logic fe_valid;
    logic q_full;
    logic q_empty;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.green  <= 16'd1610;
            r_cfg.orange <= 16'd62560;
            r_cfg.red    <= 16'd57669;
            r_cfg.track  <= 16'd10565;
            r_cfg.rise   <= 7'd22;
            r_cfg.fall   <= 7'd8;
            r_cfg.glim   <= 9'd128;
            r_cfg.olim   <= 9'd179;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_GREEN:  r_cfg.green  <= i_cfg_data;
                CFG_ORANGE: r_cfg.orange <= i_cfg_data;
                CFG_RED:    r_cfg.red    <= i_cfg_data;
                CFG_TRACK:  r_cfg.track  <= i_cfg_data;
                CFG_RISE:   r_cfg.rise   <= i_cfg_data[LVL_W-1:0];
                CFG_FALL:   r_cfg.fall   <= i_cfg_data[LVL_W-1:0];
                CFG_GLIM:   r_cfg.glim   <= i_cfg_data[LIM_W-1:0];
                CFG_OLIM:   r_cfg.olim   <= i_cfg_data[LIM_W-1:0];
                default:    r_cfg.olim   <= r_cfg.olim;
            endcase
        end
    end

    vu_front #(
        .CHANNELS (CHANNELS),
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_channel     (i_channel),
        .i_left_level  (i_left_level),
        .i_right_level (i_right_level),
        .i_muted       (i_muted),
        .i_cfg         (r_cfg),
        .o_job_valid   (fe_valid),
        .o_job         (fe_job),
        .i_job_full    (q_full)
    );

    vu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .i_data  (fe_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    vu_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job_empty     (q_empty),
        .i_job           (q_job),
        .o_job_pop       (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_side          (o_side),
        .o_segment       (o_segment),
        .o_lit           (o_lit),
        .o_segment_color (o_segment_color),
        .o_level         (o_level),
        .o_last          (o_last)
    );

endmodule

FILE: src/vu_checker.sv
module vu_checker #(
    parameter int SEGMENTS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_side,
    input logic [4:0]  o_segment,
    input logic        o_lit,
    input logic [15:0] o_segment_color,
    input logic [6:0]  o_level,
    input logic        o_last
);
    localparam logic [4:0] SEG_END = 5'(SEGMENTS - 1);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_segment_color) && $stable(o_segment)
            && $stable(o_level))
        else $error("stalled beat changed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last |-> o_side && o_segment == SEG_END)
        else $error("last flag on wrong segment");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_segment != SEG_END |=>
            empty || (o_segment == $past(o_segment) + 5'd1 && o_side == $past(o_side)
                && o_level == $past(o_level)))
        else $error("segment order broken");

    a_lit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_lit && o_segment != SEG_END |=> empty || !o_lit)
        else $error("lit segment above an unlit one");

endmodule

bind segmented_vu_meter_driver_top vu_checker #(.SEGMENTS(SEGMENTS)) u_vu_checker (.*);
